### hw/rtl/fwp_pkg.sv
// ----------------------------------------------------------------------------
// fwp_pkg
// Shared widths, coefficient table and rounding constants for the
// symmetric FIR filter with sample pass-through.
// ----------------------------------------------------------------------------
package fwp_pkg;

  localparam int TAPS         = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_W       = 16;
  localparam int COEF_COUNT   = 16;
  localparam int FRAC_BITS    = 15;
  localparam int ROUND_HALF   = 1 << (FRAC_BITS - 1);

  // Full-precision sum of TAPS products, plus one bit of headroom for rounding.
  localparam int ACC_W = SAMPLE_WIDTH + COEF_W + $clog2(TAPS) + 1;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX =
    {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN =
    {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Q1.15 coefficients; the response is symmetric about its center.
  localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_COUNT] = '{
    16'sd247,   -16'sd367,  16'sd2086,  16'sd3282,
    -16'sd1705, -16'sd7192, -16'sd2514, 16'sd7171,
    16'sd7171,  -16'sd2514, -16'sd7192, -16'sd1705,
    16'sd3282,  16'sd2086,  -16'sd367,  16'sd247
  };

  // Taps past the end of the table carry a zero weight.
  function automatic logic signed [COEF_W-1:0] coef_at(input int idx);
    if (idx < COEF_COUNT) begin
      return COEF_TABLE[idx];
    end
    return '0;
  endfunction

endpackage

### hw/rtl/fwp_in_if.sv
// ----------------------------------------------------------------------------
// fwp_in_if
// Input sample channel: valid/ready handshake with one sample per beat.
// ----------------------------------------------------------------------------
interface fwp_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [fwp_pkg::SAMPLE_WIDTH-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### hw/rtl/fwp_out_if.sv
// ----------------------------------------------------------------------------
// fwp_out_if
// Result channel: the original sample and the filtered sample per beat.
// ----------------------------------------------------------------------------
interface fwp_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [fwp_pkg::SAMPLE_WIDTH-1:0]   original_sample;
  logic signed [fwp_pkg::SAMPLE_WIDTH-1:0]   filtered_sample;

  modport source (output valid, output original_sample, output filtered_sample,
                  input ready);
  modport sink   (input valid, input original_sample, input filtered_sample,
                  output ready);
endinterface

### hw/rtl/fwp_cell.sv
// ----------------------------------------------------------------------------
// fwp_cell
// One tap of the transposed-form filter: multiplies the new sample by its
// coefficient, adds the partial sum from its upstream neighbor and holds it.
// ----------------------------------------------------------------------------
module fwp_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic signed [fwp_pkg::SAMPLE_WIDTH-1:0] x,
  input  logic signed [fwp_pkg::COEF_W-1:0]       coef,
  input  logic signed [fwp_pkg::ACC_W-1:0]        sum_in,
  output logic signed [fwp_pkg::ACC_W-1:0]        sum_out
);
  import fwp_pkg::*;

  logic signed [SAMPLE_WIDTH+COEF_W-1:0] prod;
  logic signed [ACC_W-1:0]               sum_next;

  assign prod     = x * coef;
  assign sum_next = ACC_W'(prod) + sum_in;

  // A zero partial sum is the same as an all-zero delay line.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_out <= '0;
    end else if (en) begin
      sum_out <= sum_next;
    end
  end

endmodule

### hw/rtl/fwp_out_stage.sv
// ----------------------------------------------------------------------------
// fwp_out_stage
// Takes the finished sum from the head cell, rounds, shifts and saturates
// it, and holds the result beat together with the original sample.
// ----------------------------------------------------------------------------
module fwp_out_stage (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_accept,
  input  logic signed [fwp_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic signed [fwp_pkg::ACC_W-1:0]        acc,
  output logic                                    in_ready,
  fwp_out_if.source                               out_ch
);
  import fwp_pkg::*;

  logic                            pend;
  logic signed [SAMPLE_WIDTH-1:0]  x_hold;
  logic                            move;
  logic signed [ACC_W-1:0]         rnd;
  logic signed [ACC_W-1:0]         shf;
  logic signed [SAMPLE_WIDTH-1:0]  filt_next;

  // The head cell's sum stays put until the next accepted beat, so a
  // pending sum moves out as soon as the output register is free.
  assign move     = pend && (!out_ch.valid || out_ch.ready);
  assign in_ready = !pend || move;

  assign rnd = acc + ACC_W'(ROUND_HALF);
  assign shf = rnd >>> FRAC_BITS;

  always_comb begin
    if (shf > SAT_HI) begin
      filt_next = SAMPLE_MAX;
    end else if (shf < SAT_LO) begin
      filt_next = SAMPLE_MIN;
    end else begin
      filt_next = shf[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (in_accept) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_hold <= in_sample;
    end
    if (move) begin
      out_ch.original_sample <= x_hold;
      out_ch.filtered_sample <= filt_next;
    end
  end

endmodule

### hw/rtl/fir_filter_with_passthrough_top.sv
// Path: head cell sum register, then the output register holding the result beat.
// Throughput: one sample per cycle while results are taken, set by the row of tap
// cells that all update on the same accepted beat; a stalled output holds off input.
// Reset: synchronous, active high; clears every partial sum (an all-zero
// delay line) and both valid flags. No clearing pass.
// ----------------------------------------------------------------------------
// fir_filter_with_passthrough_top
// Transposed-form symmetric FIR built as a chain of tap cells, with the
// input sample passed through beside the filtered sample.
// ----------------------------------------------------------------------------
module fir_filter_with_passthrough_top (
  input  logic     clk,
  input  logic     rst,
  fwp_in_if.sink   in_ch,
  fwp_out_if.source out_ch
);
  import fwp_pkg::*;

  logic                     accept;
  logic                     ready;
  logic signed [ACC_W-1:0]  sums [TAPS];

  assign in_ch.ready = ready;
  assign accept      = in_ch.valid && ready;

  // Cell k holds the part of future outputs that depends on samples already
  // seen; each beat shifts the partial sums one cell toward the head.
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic signed [ACC_W-1:0] upstream;
    if (k == TAPS - 1) begin : g_last
      assign upstream = '0;
    end else begin : g_mid
      assign upstream = sums[k+1];
    end

    fwp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (accept),
      .x       (in_ch.sample),
      .coef    (coef_at(k)),
      .sum_in  (upstream),
      .sum_out (sums[k])
    );
  end

  fwp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_accept (accept),
    .in_sample (in_ch.sample),
    .acc       (sums[0]),
    .in_ready  (ready),
    .out_ch    (out_ch)
  );

endmodule

### tb/fir_filter_with_passthrough_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_with_passthrough_top_tb
// Streams signed samples into the symmetric FIR and checks every result beat
// against a fixed-point software filter that tracks its own delay line. The
// run covers the zero-filled start-up, saturation at both rails, small and
// full-scale random data, and bursty, stalled and full-rate traffic.
// ----------------------------------------------------------------------------
module fir_filter_with_passthrough_top_tb;

  import fwp_pkg::*;

  localparam int NUM_COEFS  = 16;
  localparam int Q_FRAC     = 15;
  localparam longint Q_HALF = 64'sd1 <<< (Q_FRAC - 1);
  localparam int COEF_Q15 [NUM_COEFS] = '{
    247, -367, 2086, 3282, -1705, -7192, -2514, 7171,
    7171, -2514, -7192, -1705, 3282, 2086, -367, 247
  };

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t original;
    sample_t filtered;
  } fir_result_t;

  logic clk = 1'b0;
  logic rst;

  fwp_in_if  in_ch ();
  fwp_out_if out_ch ();

  fir_filter_with_passthrough_top uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  fir_result_t fir_expect_q [$];
  sample_t     tap_history [TAPS-1];

  int mismatches   = 0;
  int samples_in   = 0;
  int results_seen = 0;
  int sat_hi_seen  = 0;
  int sat_lo_seen  = 0;

  // Traffic shaping: quiet flags turn idling off on either side.
  bit tx_quiet  = 1'b0;
  bit rx_quiet  = 1'b0;
  int burst_left = 0;
  logic [11:0] stall_pattern = '1;
  int stall_pos = 0;

  // Fixed-point filter: one new sample in, one rounded and saturated output.
  function automatic sample_t filter_next(input sample_t x);
    longint acc;
    longint y;
    int k;
    acc = longint'(x) * COEF_Q15[0];
    for (k = 1; k < TAPS; k++) begin
      if (k < NUM_COEFS) begin
        acc += longint'(tap_history[k-1]) * COEF_Q15[k];
      end
    end
    for (k = TAPS - 2; k > 0; k--) begin
      tap_history[k] = tap_history[k-1];
    end
    tap_history[0] = x;
    y = (acc + Q_HALF) >>> Q_FRAC;
    if (y > longint'(SAMPLE_MAX)) begin
      y = SAMPLE_MAX;
    end else if (y < longint'(SAMPLE_MIN)) begin
      y = SAMPLE_MIN;
    end
    return sample_t'(y);
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Expected results are queued at the edge that accepts the input beat.
  always @(posedge clk) begin
    fir_result_t want;
    if (!rst && in_ch.valid && in_ch.ready) begin
      want.original = in_ch.sample;
      want.filtered = filter_next(in_ch.sample);
      if (want.filtered == SAMPLE_MAX) sat_hi_seen++;
      if (want.filtered == SAMPLE_MIN) sat_lo_seen++;
      fir_expect_q.push_back(want);
      samples_in++;
    end
  end

  always @(posedge clk) begin
    fir_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (fir_expect_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result beat orig=%0d filt=%0d",
                               out_ch.original_sample, out_ch.filtered_sample));
      end else begin
        want = fir_expect_q.pop_front();
        if (out_ch.original_sample !== want.original) begin
          log_mismatch($sformatf("result %0d original_sample exp=%0d got=%0d",
                                 results_seen, want.original, out_ch.original_sample));
        end
        if (out_ch.filtered_sample !== want.filtered) begin
          log_mismatch($sformatf("result %0d filtered_sample exp=%0d got=%0d",
                                 results_seen, want.filtered, out_ch.filtered_sample));
        end
      end
    end
  end

  // Receiver: ready follows a 12-bit stall pattern that is redrawn each time it
  // wraps; some patterns are mostly ready, others mostly stalled.
  always @(posedge clk) begin
    if (rx_quiet) begin
      out_ch.ready <= 1'b1;
    end else begin
      if (stall_pos == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          stall_pattern = 12'($urandom & $urandom);
        end else begin
          stall_pattern = 12'($urandom | $urandom);
        end
      end
      out_ch.ready <= stall_pattern[stall_pos];
      stall_pos = (stall_pos == 11) ? 0 : stall_pos + 1;
    end
  end

  // Sends one sample. The sender keeps valid high through a burst and
  // drops it for a random, possibly empty, gap between bursts.
  task automatic send_sample(input sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap = (tx_quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  // Stops sending and waits for every outstanding result, then waits on
  // so that a late extra beat would still be caught.
  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (fir_expect_q.size() != 0) begin
      @(posedge clk);
      waited++;
      if (waited > 5000) begin
        $display("Timeout waiting for %0d results", fir_expect_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
    repeat (4) @(posedge clk);
  endtask

  // Start-up and saturation: ages 0..12 carry full-scale values that match
  // the coefficient signs, so the sum overflows; first high, then low. The
  // first outputs after reset see zeros in the upper taps.
  task automatic test_saturation_rails();
    int i;
    for (i = 0; i < 13; i++) begin
      send_sample((COEF_Q15[12-i] >= 0) ? SAMPLE_MAX : SAMPLE_MIN);
    end
    for (i = 0; i < 13; i++) begin
      send_sample((COEF_Q15[12-i] >= 0) ? SAMPLE_MIN : SAMPLE_MAX);
    end
  endtask

  task automatic test_random_full_scale(input int count);
    repeat (count) send_sample(sample_t'($urandom));
  endtask

  // Small values keep the sum near zero, where rounding decides the result.
  task automatic test_random_small(input int count);
    repeat (count) send_sample(sample_t'($urandom_range(0, 512)) - sample_t'(256));
  endtask

  // Windows of sixteen large samples signed like the coefficients, with a
  // random polarity per window and some plain noise mixed in.
  task automatic test_saturating_windows(input int count);
    int i;
    bit flip;
    sample_t mag;
    flip = 1'b0;
    for (i = 0; i < count; i++) begin
      if (i % 16 == 0) flip = $urandom_range(0, 1);
      if ($urandom_range(0, 7) == 0) begin
        send_sample(sample_t'($urandom));
      end else begin
        mag = sample_t'($urandom_range(20000, 32767));
        send_sample(((COEF_Q15[15 - (i % 16)] >= 0) ^ flip) ? mag : -mag);
      end
    end
  endtask

  // Full rate on both sides: one beat per cycle with no gaps or stalls.
  task automatic test_full_rate(input int count);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    test_random_full_scale(count);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    int k;
    for (k = 0; k < TAPS - 1; k++) tap_history[k] = '0;
    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_saturation_rails();
    test_random_full_scale(600);
    wait_for_results();
    test_random_small(400);
    test_saturating_windows(400);
    test_full_rate(450);
    wait_for_results();

    $display("Run covered %0d samples and %0d result beats, %0d mismatches.",
             samples_in, results_seen, mismatches);
    $display("Saturated outputs: %0d at the top rail, %0d at the bottom rail.",
             sat_hi_seen, sat_lo_seen);
    if (mismatches == 0 && fir_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation time limit reached");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
hw/rtl/fwp_pkg.sv
hw/rtl/fwp_in_if.sv
hw/rtl/fwp_out_if.sv
hw/rtl/fwp_cell.sv
hw/rtl/fwp_out_stage.sv
hw/rtl/fir_filter_with_passthrough_top.sv
tb/fir_filter_with_passthrough_top_tb.sv
